FILE: rtl/tpst_pkg.sv
// Package for the TCP port scan tracker: sizes, codes, word structs and helpers.
// No dependencies; every other file of the block but tpst_ram imports it.
`timescale 1ns / 1ps
package tpst_pkg;

  localparam int HOSTS      = 64;
  localparam int PORT_SPACE = 65536;
  localparam int COUNT_BITS = 32;

  localparam int HOST_W  = (HOSTS > 1) ? $clog2(HOSTS) : 1;
  localparam int HCNT_W  = $clog2(HOSTS + 1);
  localparam int CNT_W   = COUNT_BITS;
  localparam int DP_W    = 17;
  localparam int PORT_W  = 16;
  localparam int FLAG_W  = 8;
  localparam int ADDR_W  = 64;
  localparam int OUT_CW  = 32;
  localparam int IDX_W   = 6;

  // Port bitmap is stored as rows of 64 bits, one row per 64 ports.
  localparam int ROW_LOG = 6;
  localparam int ROW_W   = 1 << ROW_LOG;
  localparam int RPH     = (PORT_SPACE + ROW_W - 1) / ROW_W;
  localparam int RPH_W   = (RPH > 1) ? $clog2(RPH) : 1;
  localparam int MAP_AW  = HOST_W + RPH_W;
  localparam int MAP_ROWS = 1 << MAP_AW;

  localparam int CFG_IDX_W = 3;
  localparam int CFG_DW    = 64;
  localparam logic [CFG_IDX_W-1:0] CFG_OWN_HI  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OWN_LO  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OWN_EN  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SYN     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ACK     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_FIN     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_FPU     = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_THR     = 3'd7;

  typedef enum logic [1:0] {
    ST_KNOWN = 2'd0,
    ST_NEW   = 2'd1,
    ST_OWN   = 2'd2,
    ST_FULL  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    B_CLEAR,
    B_IDLE,
    B_READ
  } b_state_t;

  typedef struct packed {
    logic [ADDR_W-1:0] own_hi;
    logic [ADDR_W-1:0] own_lo;
    logic              own_en;
    logic [FLAG_W-1:0] syn_pat;
    logic [FLAG_W-1:0] ack_pat;
    logic [FLAG_W-1:0] fin_pat;
    logic [FLAG_W-1:0] fpu_pat;
    logic [DP_W-1:0]   thr;
  } cfg_t;

  // Classified word passed from front to back.
  typedef struct packed {
    status_t           status;
    logic [HOST_W-1:0] slot;
    logic [PORT_W-1:0] port;
    logic [FLAG_W-1:0] flags;
  } mid_t;

  typedef struct packed {
    logic [DP_W-1:0]  dp;
    logic [CNT_W-1:0] syn;
    logic [CNT_W-1:0] ack;
    logic [CNT_W-1:0] fin;
    logic [CNT_W-1:0] fpu;
  } host_rec_t;

  typedef struct packed {
    status_t           status;
    logic [IDX_W-1:0]  host_index;
    logic [DP_W-1:0]   distinct_ports;
    logic [OUT_CW-1:0] syn_count;
    logic [OUT_CW-1:0] ack_count;
    logic [OUT_CW-1:0] fin_count;
    logic [OUT_CW-1:0] fpu_count;
    logic              scan_suspected;
    logic              connect_scan;
    logic              half_open_scan;
    logic              fin_scan;
    logic              fpu_scan;
  } res_t;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    return (&v) ? v : CNT_W'(v + 1'b1);
  endfunction

  function automatic logic [OUT_CW-1:0] clip32(input logic [CNT_W-1:0] v);
    if (CNT_W > OUT_CW && (v >> OUT_CW) != '0) return '1;
    return OUT_CW'(v);
  endfunction

endpackage

FILE: rtl/tpst_ram.sv
// Generic single write port RAM with one registered read port.
// No dependencies.
`timescale 1ns / 1ps
module tpst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/tpst_front.sv
// Front end: takes packet words, marks the own address, matches the host table, inserts.
// Depends on tpst_pkg.
`timescale 1ns / 1ps
module tpst_front (
  input  logic                     clk,
  input  logic                     rst_n,
  input  tpst_pkg::cfg_t           cfg,
  input  logic                     clearing,
  input  logic                     push,
  output logic                     full,
  input  logic [63:0]              src_addr_hi,
  input  logic [63:0]              src_addr_lo,
  input  logic [15:0]              dest_port,
  input  logic [7:0]               tcp_flags,
  input  logic                     mid_full,
  output logic                     mid_push,
  output tpst_pkg::mid_t           mid_item
);
  import tpst_pkg::*;

  logic              vld_r, vld_nxt;
  logic [ADDR_W-1:0] hi_r, lo_r;
  logic [PORT_W-1:0] port_r;
  logic [FLAG_W-1:0] flags_r;
  logic [HCNT_W-1:0] cnt_r, cnt_nxt;
  logic [ADDR_W-1:0] tab_hi_r [HOSTS];
  logic [ADDR_W-1:0] tab_lo_r [HOSTS];
  logic [HOSTS-1:0]  hit;
  logic [HOST_W-1:0] hit_slot;
  logic              accept, fire, own, found, is_new;
  status_t           st;

  assign full   = clearing | (vld_r & mid_full);
  assign accept = push & ~full;
  assign fire   = vld_r & ~mid_full;
  assign vld_nxt = accept | (vld_r & ~fire);

  // Full-width match against every occupied slot; at most one can hit.
  always_comb begin
    hit_slot = '0;
    for (int i = 0; i < HOSTS; i++) begin
      hit[i] = (HCNT_W'(i) < cnt_r) && (tab_hi_r[i] == hi_r) && (tab_lo_r[i] == lo_r);
      if (hit[i]) hit_slot = hit_slot | HOST_W'(i);
    end
  end

  always_comb begin
    own   = cfg.own_en && (hi_r == cfg.own_hi) && (lo_r == cfg.own_lo);
    found = |hit;
    if (own)                          st = ST_OWN;
    else if (found)                   st = ST_KNOWN;
    else if (cnt_r == HCNT_W'(HOSTS)) st = ST_FULL;
    else                              st = ST_NEW;
    is_new = fire && (st == ST_NEW);
    cnt_nxt = is_new ? HCNT_W'(cnt_r + 1'b1) : cnt_r;
    mid_item.status = st;
    mid_item.port   = port_r;
    mid_item.flags  = flags_r;
    unique case (st)
      ST_KNOWN: mid_item.slot = hit_slot;
      ST_NEW:   mid_item.slot = HOST_W'(cnt_r);
      default:  mid_item.slot = '0;
    endcase
  end

  assign mid_push = fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      vld_r <= vld_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      hi_r    <= src_addr_hi;
      lo_r    <= src_addr_lo;
      port_r  <= dest_port;
      flags_r <= tcp_flags;
    end
    if (is_new) begin
      tab_hi_r[HOST_W'(cnt_r)] <= hi_r;
      tab_lo_r[HOST_W'(cnt_r)] <= lo_r;
    end
  end

endmodule

FILE: rtl/tpst_mid_q.sv
// Two-word queue between the front end and the back end.
// Depends on tpst_pkg.
`timescale 1ns / 1ps
module tpst_mid_q (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  tpst_pkg::mid_t wdata,
  output logic           full,
  input  logic           pop,
  output logic           empty,
  output tpst_pkg::mid_t head
);
  import tpst_pkg::*;

  mid_t       q_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  assign full  = (cnt_r == 2'd2);
  assign empty = (cnt_r == 2'd0);
  assign head  = q_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop)  rp_r <= ~rp_r;
      cnt_r <= 2'(cnt_r + {1'b0, push} - {1'b0, pop});
    end
  end

  always_ff @(posedge clk) begin
    if (push) q_r[wp_r] <= wdata;
  end

endmodule

FILE: rtl/tpst_back.sv
// Back end: bitmap and counter read-modify-write, verdicts, result queue.
// Depends on tpst_pkg and tpst_ram; also runs the bitmap clearing pass after reset.
`timescale 1ns / 1ps
module tpst_back (
  input  logic           clk,
  input  logic           rst_n,
  input  tpst_pkg::cfg_t cfg,
  output logic           clearing,
  input  logic           mid_empty,
  input  tpst_pkg::mid_t mid_head,
  output logic           mid_pop,
  output logic           empty,
  input  logic           pop,
  output tpst_pkg::res_t res
);
  import tpst_pkg::*;

  b_state_t          state_r, state_nxt;
  logic [MAP_AW-1:0] clr_r, clr_nxt;
  mid_t              cur_r;

  logic              map_we, rec_we;
  logic [MAP_AW-1:0] map_waddr, map_raddr;
  logic [ROW_W-1:0]  map_wdata, map_rdata, row;
  host_rec_t         rec_rdata, rec, rec_w;
  logic              in_space, seen, sus;
  logic [ROW_LOG-1:0] bit_sel;

  res_t       oq_r [2];
  logic       owp_r, orp_r;
  logic [1:0] ocnt_r;
  logic       oq_push, oq_pop, room, take;
  res_t       res_w;

  tpst_ram #(.WIDTH(ROW_W), .DEPTH(MAP_ROWS)) u_map (
    .clk(clk), .we(map_we), .waddr(map_waddr), .wdata(map_wdata),
    .raddr(map_raddr), .rdata(map_rdata)
  );

  tpst_ram #(.WIDTH($bits(host_rec_t)), .DEPTH(1 << HOST_W)) u_rec (
    .clk(clk), .we(rec_we), .waddr(cur_r.slot), .wdata(rec_w),
    .raddr(mid_head.slot), .rdata(rec_rdata)
  );

  assign room     = (ocnt_r != 2'd2);
  assign take     = (state_r == B_IDLE) && !mid_empty && room;
  assign clearing = (state_r == B_CLEAR);
  assign map_raddr = {mid_head.slot, RPH_W'(mid_head.port >> ROW_LOG)};

  // Next state
  always_comb begin
    state_nxt = state_r;
    clr_nxt   = clr_r;
    unique case (state_r)
      B_CLEAR: begin
        clr_nxt = MAP_AW'(clr_r + 1'b1);
        if (&clr_r) state_nxt = B_IDLE;
      end
      B_IDLE: begin
        if (take && (mid_head.status == ST_KNOWN || mid_head.status == ST_NEW)) begin
          state_nxt = B_READ;
        end
      end
      B_READ:  state_nxt = B_IDLE;
      default: state_nxt = B_IDLE;
    endcase
  end

  // Record update: a new host starts from zero counters and an empty bitmap row.
  always_comb begin
    rec      = (cur_r.status == ST_NEW) ? '0 : rec_rdata;
    row      = (cur_r.status == ST_NEW) ? '0 : map_rdata;
    in_space = ({1'b0, cur_r.port} < 17'(PORT_SPACE));
    bit_sel  = cur_r.port[ROW_LOG-1:0];
    seen     = row[bit_sel];
    rec_w    = rec;
    if (in_space && !seen) rec_w.dp = DP_W'(rec.dp + 1'b1);
    if (cur_r.flags == cfg.syn_pat) rec_w.syn = sat_inc(rec.syn);
    if (cur_r.flags == cfg.ack_pat) rec_w.ack = sat_inc(rec.ack);
    if (cur_r.flags == cfg.fin_pat) rec_w.fin = sat_inc(rec.fin);
    if (cur_r.flags == cfg.fpu_pat) rec_w.fpu = sat_inc(rec.fpu);
    sus = rec_w.dp > cfg.thr;
  end

  // Outputs
  always_comb begin
    map_we    = 1'b0;
    map_waddr = {cur_r.slot, RPH_W'(cur_r.port >> ROW_LOG)};
    map_wdata = row | (ROW_W'(1) << bit_sel);
    rec_we    = 1'b0;
    mid_pop   = 1'b0;
    oq_push   = 1'b0;
    res_w     = '0;
    unique case (state_r)
      B_CLEAR: begin
        map_we    = 1'b1;
        map_waddr = clr_r;
        map_wdata = '0;
      end
      B_IDLE: begin
        mid_pop = take;
        if (take && (mid_head.status == ST_OWN || mid_head.status == ST_FULL)) begin
          oq_push      = 1'b1;
          res_w.status = mid_head.status;
        end
      end
      B_READ: begin
        map_we    = in_space;
        map_waddr = {cur_r.slot, RPH_W'(cur_r.port >> ROW_LOG)};
        rec_we    = 1'b1;
        oq_push   = 1'b1;
        res_w.status         = cur_r.status;
        res_w.host_index     = IDX_W'(cur_r.slot);
        res_w.distinct_ports = rec_w.dp;
        res_w.syn_count      = clip32(rec_w.syn);
        res_w.ack_count      = clip32(rec_w.ack);
        res_w.fin_count      = clip32(rec_w.fin);
        res_w.fpu_count      = clip32(rec_w.fpu);
        res_w.scan_suspected = sus;
        res_w.connect_scan   = sus && (rec_w.syn != '0) && (rec_w.ack != '0);
        res_w.half_open_scan = sus && (rec_w.syn != '0) && (rec_w.ack == '0);
        res_w.fin_scan       = sus && (rec_w.fin != '0);
        res_w.fpu_scan       = sus && (rec_w.fpu != '0);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_CLEAR;
      clr_r   <= '0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (mid_pop) cur_r <= mid_head;
  end

  // Result queue
  assign empty  = (ocnt_r == 2'd0);
  assign oq_pop = pop & ~empty;
  assign res    = oq_r[orp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      owp_r  <= 1'b0;
      orp_r  <= 1'b0;
      ocnt_r <= 2'd0;
    end else begin
      if (oq_push) owp_r <= ~owp_r;
      if (oq_pop)  orp_r <= ~orp_r;
      ocnt_r <= 2'(ocnt_r + {1'b0, oq_push} - {1'b0, oq_pop});
    end
  end

  always_ff @(posedge clk) begin
    if (oq_push) oq_r[owp_r] <= res_w;
  end

  a_oq_bound: assert property (@(posedge clk) disable iff (!rst_n) ocnt_r != 2'd3)
    else $error("result queue overfilled");
  a_read_one: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == B_READ |=> state_r == B_IDLE)
    else $error("read-modify-write longer than two cycles");
  a_clear_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == B_CLEAR |-> !oq_push && !mid_pop)
    else $error("traffic during bitmap clear");
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    oq_push |-> (ocnt_r != 2'd2) || oq_pop)
    else $error("push into full result queue");

endmodule

FILE: rtl/tcp_port_scan_tracker_unit.sv
// TCP port scan tracker top: configuration registers, front end, word queue, back end.
// A tracked packet word passes the front-end register, the word queue, the back end's
// read state and the result queue; the back end takes no new word until the bitmap/counter
// RAM read-modify-write is done; ignored or dropped words are queued from the idle state.
// Reset (synchronous, rst_n low): config to defaults, host table empty, then a bitmap
// clearing pass over all 65536 rows (one 64-bit row a cycle) during which full stays high.
`timescale 1ns / 1ps
module tcp_port_scan_tracker_unit (
  input  logic        clk,
  input  logic        rst_n,
  // configuration write port
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data,
  // packet words in
  input  logic        push,
  output logic        full,
  input  logic [63:0] in_src_addr_hi,
  input  logic [63:0] in_src_addr_lo,
  input  logic [15:0] in_dest_port,
  input  logic [7:0]  in_tcp_flags,
  // result words out
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  out_status,
  output logic [5:0]  out_host_index,
  output logic [16:0] out_distinct_ports,
  output logic [31:0] out_syn_count,
  output logic [31:0] out_ack_count,
  output logic [31:0] out_fin_count,
  output logic [31:0] out_fpu_count,
  output logic        out_scan_suspected,
  output logic        out_connect_scan,
  output logic        out_half_open_scan,
  output logic        out_fin_scan,
  output logic        out_fpu_scan
);
  import tpst_pkg::*;

  cfg_t cfg_r, cfg_nxt;
  logic clearing;
  logic mid_push, mid_full, mid_pop, mid_empty;
  mid_t mid_item, mid_head;
  res_t res;

  // Register writes: decode the index, keep only the register's width.
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_OWN_HI: cfg_nxt.own_hi  = cfg_data;
        CFG_OWN_LO: cfg_nxt.own_lo  = cfg_data;
        CFG_OWN_EN: cfg_nxt.own_en  = cfg_data[0];
        CFG_SYN:    cfg_nxt.syn_pat = cfg_data[FLAG_W-1:0];
        CFG_ACK:    cfg_nxt.ack_pat = cfg_data[FLAG_W-1:0];
        CFG_FIN:    cfg_nxt.fin_pat = cfg_data[FLAG_W-1:0];
        CFG_FPU:    cfg_nxt.fpu_pat = cfg_data[FLAG_W-1:0];
        CFG_THR:    cfg_nxt.thr     = cfg_data[DP_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.own_hi  <= '0;
      cfg_r.own_lo  <= '0;
      cfg_r.own_en  <= 1'b0;
      cfg_r.syn_pat <= 8'd2;
      cfg_r.ack_pat <= 8'd16;
      cfg_r.fin_pat <= 8'd1;
      cfg_r.fpu_pat <= 8'd41;
      cfg_r.thr     <= 17'd1;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Front end: hold one word, classify it against the host table, insert new hosts.
  tpst_front u_front (
    .clk(clk), .rst_n(rst_n), .cfg(cfg_r), .clearing(clearing),
    .push(push), .full(full),
    .src_addr_hi(in_src_addr_hi), .src_addr_lo(in_src_addr_lo),
    .dest_port(in_dest_port), .tcp_flags(in_tcp_flags),
    .mid_full(mid_full), .mid_push(mid_push), .mid_item(mid_item)
  );

  // Decouple classification from the RAM update so either side can stall.
  tpst_mid_q u_mid_q (
    .clk(clk), .rst_n(rst_n),
    .push(mid_push), .wdata(mid_item), .full(mid_full),
    .pop(mid_pop), .empty(mid_empty), .head(mid_head)
  );

  // Back end: update the bitmap row and counters, form verdicts, queue results.
  tpst_back u_back (
    .clk(clk), .rst_n(rst_n), .cfg(cfg_r), .clearing(clearing),
    .mid_empty(mid_empty), .mid_head(mid_head), .mid_pop(mid_pop),
    .empty(empty), .pop(pop), .res(res)
  );

  assign out_status         = res.status;
  assign out_host_index     = res.host_index;
  assign out_distinct_ports = res.distinct_ports;
  assign out_syn_count      = res.syn_count;
  assign out_ack_count      = res.ack_count;
  assign out_fin_count      = res.fin_count;
  assign out_fpu_count      = res.fpu_count;
  assign out_scan_suspected = res.scan_suspected;
  assign out_connect_scan   = res.connect_scan;
  assign out_half_open_scan = res.half_open_scan;
  assign out_fin_scan       = res.fin_scan;
  assign out_fpu_scan       = res.fpu_scan;

endmodule

FILE: test/tb_tcp_port_scan_tracker_unit.sv
// Testbench for tcp_port_scan_tracker_unit: directed packet table, then random traffic.
// Depends on tpst_pkg (sizes, status codes, register indexes, result struct).
`timescale 1ns / 1ps
module tb_tcp_port_scan_tracker_unit;
  import tpst_pkg::*;

  localparam int WATCHDOG_LIMIT = 400000;
  localparam int POOL_N = 80;
  localparam int PHASES = 6;
  localparam int ITEMS_PER_PHASE = 300;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [63:0] cfg_data;
  logic        push;
  logic        full;
  logic [63:0] in_src_addr_hi;
  logic [63:0] in_src_addr_lo;
  logic [15:0] in_dest_port;
  logic [7:0]  in_tcp_flags;
  logic        empty;
  logic        pop;
  logic [1:0]  out_status;
  logic [5:0]  out_host_index;
  logic [16:0] out_distinct_ports;
  logic [31:0] out_syn_count;
  logic [31:0] out_ack_count;
  logic [31:0] out_fin_count;
  logic [31:0] out_fpu_count;
  logic        out_scan_suspected;
  logic        out_connect_scan;
  logic        out_half_open_scan;
  logic        out_fin_scan;
  logic        out_fpu_scan;

  tcp_port_scan_tracker_unit uut (.*);

  // Shadow of the tracker: configuration, host table, port bitmap, counters.
  logic [63:0] own_hi_q, own_lo_q;
  logic        own_en_q;
  logic [7:0]  syn_pat_q, ack_pat_q, fin_pat_q, fpu_pat_q;
  logic [16:0] thr_q;
  int          host_total;
  logic [63:0] host_hi_tab [HOSTS];
  logic [63:0] host_lo_tab [HOSTS];
  bit          port_seen [HOSTS][PORT_SPACE];
  logic [16:0] dp_tab [HOSTS];
  logic [31:0] syn_tab [HOSTS], ack_tab [HOSTS], fin_tab [HOSTS], fpu_tab [HOSTS];

  res_t        pending_results [$];
  bit          failed;
  bit          no_idle;
  int          quiet_cycles = 0;
  logic [63:0] pool_hi [POOL_N];
  logic [63:0] pool_lo [POOL_N];

  typedef struct {
    logic [63:0] hi;
    logic [63:0] lo;
    logic [15:0] port;
    logic [7:0]  flags;
    bit          typed;
    res_t        want;
  } pkt_row_t;

  pkt_row_t directed_rows [$];

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic logic [31:0] bump(input logic [31:0] v);
    return (&v) ? v : v + 32'd1;
  endfunction

  // Update the shadow state for one packet and return the word it must produce.
  function automatic res_t track_packet(input logic [63:0] hi, input logic [63:0] lo,
                                        input logic [15:0] port, input logic [7:0] flags);
    res_t r;
    int   slot;
    bit   hit;
    bit   sus;
    r = '0;
    hit = 1'b0;
    slot = 0;
    if (own_en_q && hi == own_hi_q && lo == own_lo_q) begin
      r.status = ST_OWN;
      return r;
    end
    for (int i = 0; i < host_total; i++) begin
      if (!hit && host_hi_tab[i] == hi && host_lo_tab[i] == lo) begin
        hit = 1'b1;
        slot = i;
      end
    end
    if (!hit) begin
      if (host_total >= HOSTS) begin
        r.status = ST_FULL;
        return r;
      end
      // Insert a fresh host: clear its bitmap and counters before counting this packet.
      slot = host_total;
      host_total++;
      host_hi_tab[slot] = hi;
      host_lo_tab[slot] = lo;
      for (int p = 0; p < PORT_SPACE; p++) port_seen[slot][p] = 1'b0;
      dp_tab[slot] = '0;
      syn_tab[slot] = '0;
      ack_tab[slot] = '0;
      fin_tab[slot] = '0;
      fpu_tab[slot] = '0;
    end
    if (!port_seen[slot][port]) begin
      port_seen[slot][port] = 1'b1;
      dp_tab[slot] = dp_tab[slot] + 17'd1;
    end
    if (flags == syn_pat_q) syn_tab[slot] = bump(syn_tab[slot]);
    if (flags == ack_pat_q) ack_tab[slot] = bump(ack_tab[slot]);
    if (flags == fin_pat_q) fin_tab[slot] = bump(fin_tab[slot]);
    if (flags == fpu_pat_q) fpu_tab[slot] = bump(fpu_tab[slot]);
    sus = dp_tab[slot] > thr_q;
    r.status         = hit ? ST_KNOWN : ST_NEW;
    r.host_index     = slot[5:0];
    r.distinct_ports = dp_tab[slot];
    r.syn_count      = syn_tab[slot];
    r.ack_count      = ack_tab[slot];
    r.fin_count      = fin_tab[slot];
    r.fpu_count      = fpu_tab[slot];
    r.scan_suspected = sus;
    r.connect_scan   = sus && syn_tab[slot] != 0 && ack_tab[slot] != 0;
    r.half_open_scan = sus && syn_tab[slot] != 0 && ack_tab[slot] == 0;
    r.fin_scan       = sus && fin_tab[slot] != 0;
    r.fpu_scan       = sus && fpu_tab[slot] != 0;
    return r;
  endfunction

  function automatic int draw_gap();
    return no_idle ? 0 : $urandom_range(0, 11);
  endfunction

  // Drive one packet word starting at a falling edge; return at the falling edge after
  // it is taken. With no gap, push simply stays high for the next word.
  task automatic send_packet(input logic [63:0] hi, input logic [63:0] lo,
                             input logic [15:0] port, input logic [7:0] flags,
                             input bit typed, input res_t want);
    int   gap;
    res_t guess;
    gap = draw_gap();
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    push <= 1'b1;
    in_src_addr_hi <= hi;
    in_src_addr_lo <= lo;
    in_dest_port <= port;
    in_tcp_flags <= flags;
    do @(posedge clk); while (full);
    guess = track_packet(hi, lo, port, flags);
    pending_results.push_back(typed ? want : guess);
    @(negedge clk);
  endtask

  // One register write per falling edge; the caller drops cfg_we after the last one.
  task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      CFG_OWN_HI: own_hi_q = val;
      CFG_OWN_LO: own_lo_q = val;
      CFG_OWN_EN: own_en_q = val[0];
      CFG_SYN:    syn_pat_q = val[7:0];
      CFG_ACK:    ack_pat_q = val[7:0];
      CFG_FIN:    fin_pat_q = val[7:0];
      CFG_FPU:    fpu_pat_q = val[7:0];
      default:    thr_q = val[16:0];
    endcase
    @(negedge clk);
  endtask

  task automatic check_word(input res_t got);
    res_t want;
    if (pending_results.size() == 0) begin
      $error("result word with nothing expected: status=%0d", got.status);
      failed = 1'b1;
      return;
    end
    want = pending_results.pop_front();
    if (got.status !== want.status) begin
      $error("status: expected %0d, got %0d", want.status, got.status); failed = 1'b1; end
    if (got.host_index !== want.host_index) begin
      $error("host_index: expected %0d, got %0d", want.host_index, got.host_index);
      failed = 1'b1; end
    if (got.distinct_ports !== want.distinct_ports) begin
      $error("distinct_ports: expected %0d, got %0d", want.distinct_ports,
             got.distinct_ports); failed = 1'b1; end
    if (got.syn_count !== want.syn_count) begin
      $error("syn_count: expected %0d, got %0d", want.syn_count, got.syn_count);
      failed = 1'b1; end
    if (got.ack_count !== want.ack_count) begin
      $error("ack_count: expected %0d, got %0d", want.ack_count, got.ack_count);
      failed = 1'b1; end
    if (got.fin_count !== want.fin_count) begin
      $error("fin_count: expected %0d, got %0d", want.fin_count, got.fin_count);
      failed = 1'b1; end
    if (got.fpu_count !== want.fpu_count) begin
      $error("fpu_count: expected %0d, got %0d", want.fpu_count, got.fpu_count);
      failed = 1'b1; end
    if (got.scan_suspected !== want.scan_suspected) begin
      $error("scan_suspected: expected %0d, got %0d", want.scan_suspected,
             got.scan_suspected); failed = 1'b1; end
    if (got.connect_scan !== want.connect_scan) begin
      $error("connect_scan: expected %0d, got %0d", want.connect_scan, got.connect_scan);
      failed = 1'b1; end
    if (got.half_open_scan !== want.half_open_scan) begin
      $error("half_open_scan: expected %0d, got %0d", want.half_open_scan,
             got.half_open_scan); failed = 1'b1; end
    if (got.fin_scan !== want.fin_scan) begin
      $error("fin_scan: expected %0d, got %0d", want.fin_scan, got.fin_scan);
      failed = 1'b1; end
    if (got.fpu_scan !== want.fpu_scan) begin
      $error("fpu_scan: expected %0d, got %0d", want.fpu_scan, got.fpu_scan);
      failed = 1'b1; end
  endtask

  // Result side: random pop stalls, word taken at a rising edge with pop high, empty low.
  initial begin
    int   gap;
    res_t got;
    pop = 1'b0;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      gap = draw_gap();
      if (gap > 0) begin
        pop <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      pop <= 1'b1;
      do @(posedge clk); while (empty);
      got = '{status_t'(out_status), out_host_index, out_distinct_ports, out_syn_count,
              out_ack_count, out_fin_count, out_fpu_count, out_scan_suspected,
              out_connect_scan, out_half_open_scan, out_fin_scan, out_fpu_scan};
      check_word(got);
      @(negedge clk);
    end
  end

  // Watchdog: end the run when nothing moves for too long (covers the bitmap clear).
  always @(posedge clk) begin
    if ((push && !full) || (pop && !empty)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic pkt_row_t row(input logic [63:0] hi, input logic [63:0] lo,
                                   input logic [15:0] port, input logic [7:0] flags,
                                   input bit typed, input res_t want);
    pkt_row_t r;
    r.hi = hi; r.lo = lo; r.port = port; r.flags = flags; r.typed = typed; r.want = want;
    return r;
  endfunction

  initial begin
    logic [63:0] hi, lo;
    logic [15:0] port;
    logic [7:0]  flags;
    int          k;
    res_t        none;
    none = '0;
    failed = 1'b0;
    no_idle = 1'b0;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = CFG_OWN_HI;
    cfg_data = '0;
    push = 1'b0;
    in_src_addr_hi = '0;
    in_src_addr_lo = '0;
    in_dest_port = '0;
    in_tcp_flags = '0;
    own_hi_q = '0; own_lo_q = '0; own_en_q = 1'b0;
    syn_pat_q = 8'd2; ack_pat_q = 8'd16; fin_pat_q = 8'd1; fpu_pat_q = 8'd41;
    thr_q = 17'd1;
    host_total = 0;
    for (int i = 0; i < POOL_N; i++) begin
      pool_hi[i] = {$urandom, $urandom};
      pool_lo[i] = {$urandom, $urandom};
    end

    // Reset defaults: SYN 2, ACK 16, FIN 1, FPU 41, threshold 1, filter off.
    directed_rows.push_back(row('0, '0, 16'd0, 8'd2, 1,
      '{ST_NEW, 6'd0, 17'd1, 32'd1, 32'd0, 32'd0, 32'd0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0}));
    directed_rows.push_back(row('0, '0, 16'hFFFF, 8'd16, 1,
      '{ST_KNOWN, 6'd0, 17'd2, 32'd1, 32'd1, 32'd0, 32'd0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0}));
    directed_rows.push_back(row('0, '0, 16'hFFFF, 8'd1, 1,
      '{ST_KNOWN, 6'd0, 17'd2, 32'd1, 32'd1, 32'd1, 32'd0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0}));
    directed_rows.push_back(row('1, '1, 16'd80, 8'd41, 1,
      '{ST_NEW, 6'd1, 17'd1, 32'd0, 32'd0, 32'd0, 32'd1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0}));
    directed_rows.push_back(row('1, '1, 16'd81, 8'd41, 1,
      '{ST_KNOWN, 6'd1, 17'd2, 32'd0, 32'd0, 32'd0, 32'd2, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1}));
    // Half-open pattern from a third host, odd flag bytes, and a mixed address.
    directed_rows.push_back(row(64'd0, 64'd1, 16'd7, 8'd2, 0, none));
    directed_rows.push_back(row(64'd0, 64'd1, 16'd8, 8'd2, 0, none));
    directed_rows.push_back(row(64'd0, 64'd1, 16'd9, 8'hFF, 0, none));
    directed_rows.push_back(row(64'd0, 64'd1, 16'd9, 8'h00, 0, none));
    directed_rows.push_back(row(64'h8000_0000_0000_0000, '0, 16'd1, 8'd41, 0, none));
    directed_rows.push_back(row(64'h8000_0000_0000_0000, '0, 16'hFFFF, 8'd1, 0, none));
    directed_rows.push_back(row('1, '1, 16'd0, 8'd16, 0, none));

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (directed_rows[i])
      send_packet(directed_rows[i].hi, directed_rows[i].lo, directed_rows[i].port,
                  directed_rows[i].flags, directed_rows[i].typed, directed_rows[i].want);

    for (int ph = 0; ph < PHASES; ph++) begin
      // Drain, let the pipe settle, then reprogram the registers; phase 4 keeps the own address.
      push <= 1'b0;
      while (pending_results.size() != 0) @(negedge clk);
      repeat (8) @(negedge clk);
      case (ph)
        0: begin
          write_reg(CFG_OWN_HI, pool_hi[3]); write_reg(CFG_OWN_LO, pool_lo[3]);
          write_reg(CFG_OWN_EN, 64'd1);
          write_reg(CFG_SYN, 64'd2); write_reg(CFG_ACK, 64'd16);
          write_reg(CFG_FIN, 64'd1); write_reg(CFG_FPU, 64'd41);
          write_reg(CFG_THR, 64'd1);
        end
        1: begin
          write_reg(CFG_OWN_HI, '0); write_reg(CFG_OWN_LO, '0);
          write_reg(CFG_OWN_EN, 64'd1);
          write_reg(CFG_SYN, 64'd0); write_reg(CFG_ACK, 64'hFF);
          write_reg(CFG_FIN, 64'h11); write_reg(CFG_FPU, 64'h29);
          write_reg(CFG_THR, 64'd0);
        end
        2: begin
          write_reg(CFG_OWN_HI, '1); write_reg(CFG_OWN_LO, '1);
          write_reg(CFG_OWN_EN, 64'd0);
          write_reg(CFG_SYN, 64'($urandom_range(0, 255)));
          write_reg(CFG_ACK, 64'($urandom_range(0, 255)));
          write_reg(CFG_FIN, 64'($urandom_range(0, 255)));
          write_reg(CFG_FPU, 64'($urandom_range(0, 255)));
          write_reg(CFG_THR, 64'd65536);
        end
        3: begin
          k = $urandom_range(0, POOL_N - 1);
          write_reg(CFG_OWN_HI, pool_hi[k]); write_reg(CFG_OWN_LO, pool_lo[k]);
          write_reg(CFG_OWN_EN, 64'd1);
          write_reg(CFG_SYN, 64'd2); write_reg(CFG_ACK, 64'd18);
          write_reg(CFG_FIN, 64'd1); write_reg(CFG_FPU, 64'd41);
          write_reg(CFG_THR, 64'd3);
        end
        4: begin
          write_reg(CFG_OWN_EN, 64'd0);
          write_reg(CFG_SYN, 64'($urandom_range(0, 255)));
          write_reg(CFG_ACK, 64'($urandom_range(0, 255)));
          write_reg(CFG_FIN, 64'($urandom_range(0, 255)));
          write_reg(CFG_FPU, 64'($urandom_range(0, 255)));
          write_reg(CFG_THR, 64'($urandom_range(0, 40)));
        end
        default: begin
          write_reg(CFG_OWN_HI, '1); write_reg(CFG_OWN_LO, '1);
          write_reg(CFG_OWN_EN, 64'd1);
          write_reg(CFG_SYN, 64'd2); write_reg(CFG_ACK, 64'd16);
          write_reg(CFG_FIN, 64'd1); write_reg(CFG_FPU, 64'd41);
          write_reg(CFG_THR, 64'd8);
        end
      endcase
      cfg_we <= 1'b0;
      no_idle = (ph == 2);

      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        k = $urandom_range(0, 99);
        if (k < 8 && own_en_q) begin
          hi = own_hi_q; lo = own_lo_q;
        end else if (k < 16) begin
          hi = {$urandom, $urandom}; lo = {$urandom, $urandom};
        end else begin
          // Bias toward a few busy hosts so scans build up, the rest overflow the table.
          k = ($urandom_range(0, 3) == 0) ? $urandom_range(0, POOL_N - 1)
                                          : $urandom_range(0, 9);
          hi = pool_hi[k]; lo = pool_lo[k];
        end
        k = $urandom_range(0, 9);
        if (k < 5) port = 16'($urandom_range(0, 15));
        else if (k < 9) port = 16'($urandom);
        else port = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
        case ($urandom_range(0, 9))
          0, 1:    flags = syn_pat_q;
          2, 3:    flags = ack_pat_q;
          4:       flags = fin_pat_q;
          5:       flags = fpu_pat_q;
          default: flags = 8'($urandom);
        endcase
        send_packet(hi, lo, port, flags, 0, none);
      end
    end

    push <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
    if (!failed && pending_results.size() == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
